// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent assertions with synchronous reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Checks that one condition implies another in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- rtl/rc4m_pkg.sv -----
// ----------------------------------------------------------------------------
// rc4m_pkg
// Types and constants shared by the RC4 cipher engine, its permutation
// memory and the top level.
// ----------------------------------------------------------------------------
package rc4m_pkg;

    localparam int BYTE_W      = 8;
    localparam int SBOX_DEPTH  = 256;
    localparam int SBOX_AW     = 8;
    localparam int KEY_WORDS   = 4;
    localparam int KEY_WORD_W  = 64;
    localparam int KEY_BYTES   = 32;
    localparam int KEY_SEL_W   = 5;
    localparam int KEY_LEN_W   = 6;
    localparam int CFG_ADDR_W  = 3;

    localparam logic [CFG_ADDR_W-1:0] REG_KEY0     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_KEY1     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_KEY2     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_KEY3     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_KEY_LEN  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_OUT_MASK = 3'd5;

    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET  = 6'd32;
    localparam logic [BYTE_W-1:0]    OUT_MASK_RESET = 8'd42;
    localparam logic [SBOX_AW-1:0]   SBOX_LAST      = 8'hFF;

    typedef logic [KEY_BYTES-1:0][BYTE_W-1:0] key_bytes_t;

    typedef struct packed {
        logic               we;
        logic [SBOX_AW-1:0] waddr;
        logic [BYTE_W-1:0]  wdata;
        logic               re;
        logic [SBOX_AW-1:0] raddr;
    } mem_req_t;

endpackage

// ----- rtl/rc4_stream_cipher_with_output_mask_core.sv -----
// ----------------------------------------------------------------------------
// rc4_stream_cipher_with_output_mask_core
// RC4 byte cipher whose output is XORed with a programmable mask. Holds the
// key and mask registers and connects the sequencer to the permutation memory.
// ----------------------------------------------------------------------------
//  Channel   Ports                    Payload
//  input     s_tvalid/s_tready        s_tdata = data_in, s_tuser = start_of_message
//  output    m_tvalid/m_tready        m_tdata = data_out
//  config    cfg_valid/cfg_ready      cfg_addr = register index, cfg_wdata = value
//
// After an input transfer the result is registered once the dependent reads
// and the two write-backs on the single write port of the permutation memory
// are done; only then is the next byte taken, so one byte is in flight.
// A byte that rekeys first loads the identity permutation, then does the key
// swaps entry by entry, and then restarts the generator.
// Reset clears the control state only; the permutation is written by the
// first key schedule. A result waits in the output register while the next
// byte is taken; the sequencer stalls only when a second result is ready.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rc4_stream_cipher_with_output_mask_core
    import rc4m_pkg::*;
#(
    parameter int MAX_KEY_BYTES = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] data_in
    input  logic                  s_tuser,   // [0] start_of_message
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [7:0] data_out
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [KEY_WORD_W-1:0] cfg_wdata
);

    logic [KEY_WORDS-1:0][KEY_WORD_W-1:0] key_words_reg;
    logic [KEY_LEN_W-1:0]                 key_len_reg;
    logic [BYTE_W-1:0]                    out_mask_reg;
    logic [KEY_LEN_W-1:0]                 key_len_eff;
    key_bytes_t                           key_bytes;
    mem_req_t                             mem_req;
    logic [BYTE_W-1:0]                    mem_rdata;
    logic                                 in_xfer;
    logic                                 init_wr0;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_words_reg <= '0;
            key_len_reg   <= KEY_LEN_RESET;
            out_mask_reg  <= OUT_MASK_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_addr)
                REG_KEY0:     key_words_reg[0] <= cfg_wdata;
                REG_KEY1:     key_words_reg[1] <= cfg_wdata;
                REG_KEY2:     key_words_reg[2] <= cfg_wdata;
                REG_KEY3:     key_words_reg[3] <= cfg_wdata;
                REG_KEY_LEN:  key_len_reg      <= cfg_wdata[KEY_LEN_W-1:0];
                REG_OUT_MASK: out_mask_reg     <= cfg_wdata[BYTE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        priority if (key_len_reg == '0) begin
            key_len_eff = 6'd1;
        end else if (key_len_reg > KEY_LEN_W'(MAX_KEY_BYTES)) begin
            key_len_eff = KEY_LEN_W'(MAX_KEY_BYTES);
        end else begin
            key_len_eff = key_len_reg;
        end
    end

    assign key_bytes = key_bytes_t'(key_words_reg);

    rc4m_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .s_data    (s_tdata),
        .s_start   (s_tuser),
        .key       (key_bytes),
        .key_len   (key_len_eff),
        .out_mask  (out_mask_reg),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_data    (m_tdata),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    rc4m_sbox_ram u_sbox (
        .aclk  (aclk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    assign in_xfer  = s_tvalid && s_tready;
    assign init_wr0 = mem_req.we && (mem_req.waddr == 8'd0);

    `ASSERT_NEXT(a_one_item, aclk, aresetn, in_xfer, !s_tready, "second transfer while busy")
    `ASSERT_CLK(a_no_write_idle, aclk, aresetn, !(mem_req.we && s_tready), "write while idle")
    `ASSERT_NEXT(a_init_start, aclk, aresetn, in_xfer && s_tuser, init_wr0, "rekey skipped entry 0")

endmodule

// ----- rtl/rc4m_sbox_ram.sv -----
// ----------------------------------------------------------------------------
// rc4m_sbox_ram
// Permutation memory: 256 bytes, one write port and one read port with a
// registered read that holds its data while no read is issued.
// ----------------------------------------------------------------------------
module rc4m_sbox_ram
    import rc4m_pkg::*;
(
    input  logic              aclk,
    input  mem_req_t          req,
    output logic [BYTE_W-1:0] rdata
);

    logic [BYTE_W-1:0] mem [SBOX_DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re) begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/rc4m_engine.sv -----
// ----------------------------------------------------------------------------
// rc4m_engine
// Sequencer for the RC4 key schedule and keystream generator. It drives the
// permutation memory, keeps both indices and holds one finished result.
// ----------------------------------------------------------------------------
module rc4m_engine
    import rc4m_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [BYTE_W-1:0]    s_data,
    input  logic                 s_start,
    input  key_bytes_t           key,
    input  logic [KEY_LEN_W-1:0] key_len,
    input  logic [BYTE_W-1:0]    out_mask,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [BYTE_W-1:0]    m_data,
    output mem_req_t             mem_req,
    input  logic [BYTE_W-1:0]    mem_rdata
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_K_RD,
        ST_K_RJ,
        ST_K_WN,
        ST_K_WJ,
        ST_P_RI,
        ST_P_RJ,
        ST_P_WI,
        ST_P_WJ,
        ST_P_OUT
    } state_t;

    state_t               state_reg;
    logic [SBOX_AW-1:0]   i_reg;
    logic [SBOX_AW-1:0]   j_reg;
    logic [SBOX_AW-1:0]   n_reg;
    logic [KEY_SEL_W-1:0] k_reg;
    logic                 keyed_reg;
    logic [BYTE_W-1:0]    a_reg;
    logic [SBOX_AW-1:0]   t_reg;
    logic [BYTE_W-1:0]    data_reg;
    logic                 m_valid_reg;
    logic [BYTE_W-1:0]    m_data_reg;

    logic                 accept;
    logic                 out_free;
    logic [SBOX_AW-1:0]   i_next;
    logic [SBOX_AW-1:0]   j_ks_next;
    logic [SBOX_AW-1:0]   j_pr_next;
    logic [BYTE_W-1:0]    ks_byte;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign i_next    = i_reg + 8'd1;
    assign j_ks_next = j_reg + mem_rdata + key[k_reg];
    assign j_pr_next = j_reg + mem_rdata;
    assign ks_byte   = (t_reg == j_reg) ? a_reg : mem_rdata;

    always_comb begin
        mem_req = '0;
        unique case (state_reg)
            ST_IDLE: begin
                mem_req.re    = accept && !(s_start || !keyed_reg);
                mem_req.raddr = i_next;
            end
            ST_INIT: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = n_reg;
                mem_req.wdata = n_reg;
            end
            ST_K_RD: begin
                mem_req.re    = 1'b1;
                mem_req.raddr = n_reg;
            end
            ST_K_RJ: begin
                mem_req.re    = 1'b1;
                mem_req.raddr = j_ks_next;
            end
            ST_K_WN: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = n_reg;
                mem_req.wdata = mem_rdata;
            end
            ST_K_WJ: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = j_reg;
                mem_req.wdata = a_reg;
            end
            ST_P_RI: begin
                mem_req.re    = 1'b1;
                mem_req.raddr = i_next;
            end
            ST_P_RJ: begin
                mem_req.re    = 1'b1;
                mem_req.raddr = j_pr_next;
            end
            ST_P_WI: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = i_reg;
                mem_req.wdata = mem_rdata;
            end
            ST_P_WJ: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = j_reg;
                mem_req.wdata = a_reg;
                mem_req.re    = 1'b1;
                mem_req.raddr = t_reg;
            end
            ST_P_OUT: begin
                mem_req = '0;
            end
            default: begin
                mem_req = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            i_reg       <= '0;
            j_reg       <= '0;
            n_reg       <= '0;
            k_reg       <= '0;
            keyed_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != ST_P_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        data_reg <= s_data;
                        if (s_start || !keyed_reg) begin
                            n_reg     <= '0;
                            state_reg <= ST_INIT;
                        end else begin
                            i_reg     <= i_next;
                            state_reg <= ST_P_RJ;
                        end
                    end
                end
                ST_INIT: begin
                    n_reg <= n_reg + 8'd1;
                    if (n_reg == SBOX_LAST) begin
                        j_reg     <= '0;
                        k_reg     <= '0;
                        state_reg <= ST_K_RD;
                    end
                end
                ST_K_RD: begin
                    state_reg <= ST_K_RJ;
                end
                ST_K_RJ: begin
                    a_reg     <= mem_rdata;
                    j_reg     <= j_ks_next;
                    state_reg <= ST_K_WN;
                end
                ST_K_WN: begin
                    state_reg <= ST_K_WJ;
                end
                ST_K_WJ: begin
                    if ((KEY_LEN_W'(k_reg) + 6'd1) >= key_len) begin
                        k_reg <= '0;
                    end else begin
                        k_reg <= k_reg + 5'd1;
                    end
                    n_reg <= n_reg + 8'd1;
                    if (n_reg == SBOX_LAST) begin
                        i_reg     <= '0;
                        j_reg     <= '0;
                        keyed_reg <= 1'b1;
                        state_reg <= ST_P_RI;
                    end else begin
                        state_reg <= ST_K_RD;
                    end
                end
                ST_P_RI: begin
                    i_reg     <= i_next;
                    state_reg <= ST_P_RJ;
                end
                ST_P_RJ: begin
                    a_reg     <= mem_rdata;
                    j_reg     <= j_pr_next;
                    state_reg <= ST_P_WI;
                end
                ST_P_WI: begin
                    t_reg     <= a_reg + mem_rdata;
                    state_reg <= ST_P_WJ;
                end
                ST_P_WJ: begin
                    state_reg <= ST_P_OUT;
                end
                ST_P_OUT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= data_reg ^ ks_byte ^ out_mask;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- sim/rc4_stream_cipher_with_output_mask_core_tb.sv -----
// ----------------------------------------------------------------------------
// rc4_stream_cipher_with_output_mask_core_tb
// Self-checking testbench for the masked RC4 byte cipher. A clocked driver
// feeds bytes from a queue and a clocked monitor checks every output transfer
// against a cycle-free RC4 predictor with its own key, mask and permutation.
// Directed bytes cover the first byte without a key, the key length limits,
// spare register indexes and mask changes. Random messages follow under
// several key settings, with random idle cycles on both sides.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_with_output_mask_core_tb;
    import rc4m_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int IDLE_PCT     = 38;
    localparam int RANDOM_BYTES = 900;
    localparam int TAIL_CYCLES  = 40;
    localparam int CYCLE_LIMIT  = 6_000_000;

    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = 3'd7;
    localparam logic [CFG_ADDR_W-1:0] KEY_REGS [KEY_WORDS] =
        '{REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3};

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              som;
    } byte_item_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [7:0]            m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [KEY_WORD_W-1:0] cfg_wdata = '0;

    byte_item_t        pending_bytes [$];
    logic [BYTE_W-1:0] expected_bytes [$];
    byte_item_t        accepted_item;
    logic [BYTE_W-1:0] expected_out;

    int idle_pct        = IDLE_PCT;
    int bytes_queued    = 0;
    int bytes_accepted  = 0;
    int results_checked = 0;
    int messages_queued = 0;
    int rekey_count     = 0;
    int config_writes   = 0;
    int key_settings    = 0;
    int mismatch_count  = 0;
    int cycle_count     = 0;

    logic [BYTE_W-1:0]     sbox [SBOX_DEPTH];
    logic [BYTE_W-1:0]     gen_i;
    logic [BYTE_W-1:0]     gen_j;
    logic                  have_key;
    logic [KEY_WORD_W-1:0] key_word [KEY_WORDS];
    logic [KEY_LEN_W-1:0]  key_len;
    logic [BYTE_W-1:0]     out_mask;

    rc4_stream_cipher_with_output_mask_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [7:0] data_in
        .s_tuser   (s_tuser),    // [0] start_of_message
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // [7:0] data_out
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    function automatic void schedule_key();
        int                len;
        int                k;
        logic [BYTE_W-1:0] j;
        logic [BYTE_W-1:0] t;
        logic [BYTE_W-1:0] kb;
        len = key_len;
        if (len == 0) len = 1;
        if (len > KEY_BYTES) len = KEY_BYTES;
        for (int n = 0; n < SBOX_DEPTH; n++) sbox[8'(n)] = 8'(n);
        j = '0;
        k = 0;
        for (int n = 0; n < SBOX_DEPTH; n++) begin
            kb = key_word[2'(k / 8)][(k % 8) * 8 +: 8];
            t = sbox[8'(n)];
            j = j + t + kb;
            sbox[8'(n)] = sbox[j];
            sbox[j] = t;
            k++;
            if (k >= len) k = 0;
        end
        gen_i = '0;
        gen_j = '0;
        have_key = 1'b1;
        rekey_count++;
    endfunction

    function automatic logic [BYTE_W-1:0] cipher_byte(input logic [BYTE_W-1:0] din,
                                                      input logic som);
        logic [BYTE_W-1:0] a;
        logic [BYTE_W-1:0] b;
        if (som || !have_key) schedule_key();
        gen_i = gen_i + 8'd1;
        a = sbox[gen_i];
        gen_j = gen_j + a;
        b = sbox[gen_j];
        sbox[gen_i] = b;
        sbox[gen_j] = a;
        return din ^ sbox[8'(a + b)] ^ out_mask;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                accepted_item = pending_bytes.pop_front();
                expected_bytes.push_back(cipher_byte(accepted_item.data, accepted_item.som));
                bytes_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_bytes.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_bytes[0].data;
                    s_tuser  <= pending_bytes[0].som;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_bytes.size() == 0) begin
                    $display("%0t: unexpected transfer, expected none, actual %02h",
                             $time, m_tdata);
                    mismatch_count++;
                end else begin
                    expected_out = expected_bytes.pop_front();
                    results_checked++;
                    if (m_tdata !== expected_out) begin
                        $display("%0t: data_out mismatch, expected %02h, actual %02h",
                                 $time, expected_out, m_tdata);
                        mismatch_count++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out with %0d bytes pending and %0d results outstanding.",
                     pending_bytes.size(), expected_bytes.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [KEY_WORD_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        config_writes++;
        case (idx)
            REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: key_word[idx[1:0]] = val;
            REG_KEY_LEN:  key_len  = val[KEY_LEN_W-1:0];
            REG_OUT_MASK: out_mask = val[BYTE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic drain_pipeline();
        while (pending_bytes.size() != 0 || s_tvalid || expected_bytes.size() != 0)
            @(posedge aclk);
    endtask

    task automatic queue_byte(input logic [BYTE_W-1:0] data, input logic som);
        byte_item_t item;
        item.data = data;
        item.som  = som;
        pending_bytes.push_back(item);
        bytes_queued++;
    endtask

    // A broken message continues the running keystream instead of rekeying.
    task automatic queue_message(input int len);
        logic broken;
        broken = ($urandom_range(7) == 0);
        for (int n = 0; n < len; n++) begin
            if (n == 0) queue_byte(8'($urandom), !broken);
            else queue_byte(8'($urandom), $urandom_range(19) == 0);
        end
        messages_queued++;
    endtask

    task automatic load_random_config();
        logic [KEY_WORD_W-1:0] val;
        for (int w = 0; w < KEY_WORDS; w++) begin
            case ($urandom_range(7))
                0:       val = '0;
                1:       val = '1;
                default: val = {$urandom, $urandom};
            endcase
            write_reg(KEY_REGS[2'(w)], val);
        end
        val = {$urandom, $urandom};
        case ($urandom_range(9))
            0:       val[KEY_LEN_W-1:0] = '0;
            1:       val[KEY_LEN_W-1:0] = 6'($urandom_range(KEY_BYTES + 1, 63));
            2:       val[KEY_LEN_W-1:0] = 6'd1;
            3:       val[KEY_LEN_W-1:0] = 6'(KEY_BYTES);
            default: val[KEY_LEN_W-1:0] = 6'($urandom_range(1, KEY_BYTES));
        endcase
        write_reg(REG_KEY_LEN, val);
        val = {$urandom, $urandom};
        case ($urandom_range(5))
            0:       val[BYTE_W-1:0] = '0;
            1:       val[BYTE_W-1:0] = '1;
            default: ;
        endcase
        write_reg(REG_OUT_MASK, val);
        if ($urandom_range(3) == 0)
            write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO,
                      {$urandom, $urandom});
        key_settings++;
    endtask

    initial begin
        int budget;
        int len;
        int phase;
        for (int w = 0; w < KEY_WORDS; w++) key_word[2'(w)] = '0;
        key_len  = KEY_LEN_RESET;
        out_mask = OUT_MASK_RESET;
        have_key = 1'b0;
        gen_i    = '0;
        gen_j    = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings; the first byte must key the cipher on its own.
        key_settings++;
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h55, 1'b0);
        queue_byte(8'hAA, 1'b1);
        queue_byte(8'h01, 1'b0);
        drain_pipeline();

        // One-byte key of all ones, plain RC4; spare indexes must be ignored.
        write_reg(REG_KEY0, '1);
        write_reg(REG_KEY_LEN, 64'd1);
        write_reg(REG_OUT_MASK, 64'd0);
        write_reg(REG_SPARE_LO, '1);
        write_reg(REG_SPARE_HI, '1);
        key_settings++;
        queue_byte(8'h00, 1'b1);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h80, 1'b0);
        drain_pipeline();

        // A zero key length behaves as one byte.
        write_reg(REG_KEY0, 64'h0123_4567_89AB_CDEF);
        write_reg(REG_KEY_LEN, 64'd0);
        write_reg(REG_OUT_MASK, 64'hFF);
        key_settings++;
        queue_byte(8'h00, 1'b1);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h7F, 1'b0);
        drain_pipeline();

        // Oversized key length saturates to the full key.
        for (int w = 0; w < KEY_WORDS; w++) write_reg(KEY_REGS[2'(w)], '1);
        write_reg(REG_KEY_LEN, 64'd63);
        write_reg(REG_OUT_MASK, 64'h5A);
        key_settings++;
        queue_byte(8'h12, 1'b1);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h00, 1'b0);
        drain_pipeline();

        // The mask applies at once, the new key only after the next rekey.
        write_reg(REG_OUT_MASK, 64'h00);
        write_reg(REG_KEY0, 64'hFEDC_BA98_7654_3210);
        write_reg(REG_KEY_LEN, 64'd32);
        key_settings++;
        queue_byte(8'h34, 1'b0);
        queue_byte(8'h56, 1'b0);
        queue_byte(8'h78, 1'b1);
        queue_byte(8'h9A, 1'b0);
        drain_pipeline();

        phase = 0;
        while (bytes_queued < RANDOM_BYTES + 20) begin
            drain_pipeline();
            load_random_config();
            idle_pct = (phase == 2) ? 0 : IDLE_PCT;
            budget = $urandom_range(60, 120);
            while (budget > 0) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
                if (len > budget) len = budget;
                queue_message(len);
                budget -= len;
                if ($urandom_range(15) == 0) drain_pipeline();
            end
            phase++;
        end

        drain_pipeline();
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("Checked %0d of %0d bytes in %0d random messages, %0d rekeys.",
                 results_checked, bytes_accepted, messages_queued, rekey_count);
        $display("Used %0d key settings over %0d register writes.",
                 key_settings, config_writes);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
